// ===== sv/vpss_pkg.sv =====
// Package: request and result types, state codes and register indexes of the power sequencer.
package vpss_pkg;

  localparam int BuzzerW = 10;
  localparam int HvW     = 8;
  localparam int MsgW    = 8;
  localparam int ModeW   = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 10;

  localparam logic [ModeW-1:0] MODE_LV     = 2'd0;
  localparam logic [ModeW-1:0] MODE_HV     = 2'd1;
  localparam logic [ModeW-1:0] MODE_RTD    = 2'd2;
  localparam logic [ModeW-1:0] MODE_FAILED = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_BUZZER_TICKS     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HV_TIMEOUT_TICKS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STATUS_PRESCALE  = 2'd2;

  localparam logic [BuzzerW-1:0] BUZZER_TICKS_RST     = 10'd250;
  localparam logic [HvW-1:0]     HV_TIMEOUT_TICKS_RST = 8'd10;
  localparam logic [MsgW-1:0]    STATUS_PRESCALE_RST  = 8'd10;

  typedef struct packed {
    logic inverters_invalid;
    logic eeprom_ready;
    logic bms_valid;
    logic contactor_closed;
    logic braking;
    logic accelerating;
    logic button_line;
    logic torque_plausible;
  } vpss_in_t;

  typedef struct packed {
    logic [ModeW-1:0] vehicle_state;
    logic             cooling_on;
    logic             buzzer_on;
    logic             fault_led;
    logic             brake_light;
    logic             send_status;
  } vpss_out_t;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [HvW-1:0]     hv_ticks_left;
    logic [BuzzerW-1:0] buzzer_ticks_left;
    logic [MsgW-1:0]    message_count;
  } vpss_state_t;

  typedef struct packed {
    logic [BuzzerW-1:0] buzzer_ticks;
    logic [HvW-1:0]     hv_timeout_ticks;
    logic [MsgW-1:0]    status_prescale;
  } vpss_cfg_t;

endpackage

// ===== sv/vpss_step.sv =====
// Next-state and result logic for one control tick.
module vpss_step
  import vpss_pkg::*;
(
  input  vpss_in_t    req,
  input  vpss_state_t cur,
  input  vpss_cfg_t   cfg,
  output vpss_state_t nxt,
  output vpss_out_t   res
);

  logic             hv_on;
  logic             rtd_entry;
  logic [ModeW-1:0] m;
  logic [HvW-1:0]   hv;
  logic [BuzzerW-1:0] bz;
  logic [MsgW-1:0]  cnt_inc;
  logic             send;

  assign hv_on   = req.bms_valid & req.contactor_closed;
  // start: brake held, no throttle, button pressed (active low)
  assign rtd_entry = req.braking & ~req.accelerating & ~req.button_line;
  assign cnt_inc = cur.message_count + MsgW'(1);
  assign send    = (cnt_inc >= cfg.status_prescale);

  always_comb begin
    hv = (cur.hv_ticks_left != '0) ? cur.hv_ticks_left - HvW'(1) : cur.hv_ticks_left;
    bz = (cur.buzzer_ticks_left != '0) ? cur.buzzer_ticks_left - BuzzerW'(1)
                                       : cur.buzzer_ticks_left;
    m = (cur.mode == MODE_FAILED) ? MODE_LV : cur.mode;
    if (req.inverters_invalid || !req.eeprom_ready) begin
      m = MODE_FAILED;
    end
    case (m)
      MODE_LV: begin
        if (hv_on) begin
          m = MODE_HV;
        end
      end
      MODE_HV, MODE_RTD: begin
        if (m == MODE_HV && rtd_entry) begin
          m  = MODE_RTD;
          bz = cfg.buzzer_ticks;
        end
        // timeout check uses the already decremented count
        if (hv_on) begin
          hv = cfg.hv_timeout_ticks;
        end else if (hv == '0) begin
          m = MODE_LV;
        end
      end
      default: begin
      end
    endcase
  end

  assign nxt.mode              = m;
  assign nxt.hv_ticks_left     = hv;
  assign nxt.buzzer_ticks_left = bz;
  assign nxt.message_count     = send ? '0 : cnt_inc;

  assign res.vehicle_state = m;
  assign res.cooling_on    = (m == MODE_HV) || (m == MODE_RTD);
  assign res.buzzer_on     = (bz != '0);
  assign res.fault_led     = ~req.torque_plausible | (m == MODE_FAILED);
  assign res.brake_light   = req.braking;
  assign res.send_status   = send;

endmodule

// ===== sv/vehicle_power_state_sequencer.sv =====
// Top level of the vehicle power state sequencer: state, config and result registers.
// A request's result is registered when the request is accepted and shows in the next cycle.
// Throughput: one request per cycle; the single result register is the only stage,
// and a new request is taken whenever that register is empty or being drained.
// Reset (rst, synchronous, active high): mode low voltage, all countdowns and the
// message count zero, registers back to buzzer 250, timeout 10, prescale 10.
module vehicle_power_state_sequencer
  import vpss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  vpss_in_t           in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output vpss_out_t          out_data,
  // configuration write port
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  vpss_cfg_t   cfg;
  vpss_state_t state;
  vpss_state_t state_next;
  vpss_out_t   res_next;
  logic        in_fire;

  // The result register frees up in the same cycle it is drained, so the
  // request side never stalls behind a result that is about to leave.
  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  // Configuration registers; indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buzzer_ticks     <= BUZZER_TICKS_RST;
      cfg.hv_timeout_ticks <= HV_TIMEOUT_TICKS_RST;
      cfg.status_prescale  <= STATUS_PRESCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUZZER_TICKS:     cfg.buzzer_ticks     <= cfg_data;
        REG_HV_TIMEOUT_TICKS: cfg.hv_timeout_ticks <= cfg_data[HvW-1:0];
        REG_STATUS_PRESCALE:  cfg.status_prescale  <= cfg_data[MsgW-1:0];
        default: begin
        end
      endcase
    end
  end

  // One tick of sequencing: mode, the two countdowns and the prescaler.
  vpss_step u_step (
    .req (in_data),
    .cur (state),
    .cfg (cfg),
    .nxt (state_next),
    .res (res_next)
  );

  // State advances only on an accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode              <= MODE_LV;
      state.hv_ticks_left     <= '0;
      state.buzzer_ticks_left <= '0;
      state.message_count     <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res_next;
    end
  end

  // Checks
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted request produced no result");

  a_state_matches_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.vehicle_state == state.mode)
    else $error("held result disagrees with mode register");

  a_cooling_tracks_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cooling_on ==
      (out_data.vehicle_state == MODE_HV || out_data.vehicle_state == MODE_RTD))
    else $error("cooling output inconsistent with vehicle state");

  a_buzzer_tracks_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.buzzer_on == (state.buzzer_ticks_left != '0))
    else $error("buzzer output inconsistent with countdown");

endmodule

// ===== verif/tb_vehicle_power_state_sequencer.sv =====
// Testbench: power sequencer requests checked against a cycle-free predictor, with random idling.
`timescale 1ns / 1ps

module tb_vehicle_power_state_sequencer;
  import vpss_pkg::*;

  // Worst correct run is about 700 requests plus one long hold-off;
  // this leaves a wide margin.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_OFF_CYCLES = 80;

  // Named request patterns, bit order as in vpss_in_t:
  // inv_invalid, eeprom_ready, bms_valid, contactor, braking, accel, button_line, plausible.
  localparam vpss_in_t REQ_LV_IDLE    = 8'h43; // healthy, no HV, button released
  localparam vpss_in_t REQ_INV_BAD    = 8'hC3; // inverters invalid
  localparam vpss_in_t REQ_EEPROM_OFF = 8'h03; // memory not ready
  localparam vpss_in_t REQ_HV_UP      = 8'h73; // bms valid and contactor closed
  localparam vpss_in_t REQ_RTD_NO_HV  = 8'h49; // brake + button pressed, HV absent
  localparam vpss_in_t REQ_IMPLAUS    = 8'h72; // HV up, torque implausible
  localparam vpss_in_t REQ_RTD_ACCEL  = 8'h7D; // brake + accel + button: no RTD entry
  localparam vpss_in_t REQ_RTD_GO     = 8'h79; // HV up, brake, button pressed
  localparam vpss_in_t REQ_BMS_ONLY   = 8'h63; // contactor open
  localparam vpss_in_t REQ_CONT_ONLY  = 8'h53; // bms invalid
  localparam vpss_in_t REQ_ALL_ONES   = 8'hFF;
  localparam vpss_in_t REQ_ALL_ZEROS  = 8'h00;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  vpss_in_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  vpss_out_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_BUZZER_TICKS;
  logic [CfgW-1:0]     cfg_data = '0;

  // Predictor state and shadow of the config registers.
  vpss_state_t veh;
  vpss_cfg_t   regs;

  vpss_out_t   due_outputs[$];   // predicted status, oldest first
  vpss_out_t   want;
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;

  // Idling knobs: sender gaps, receiver stalls, and a one-shot long hold-off.
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int          hold_cycles = 0;

  always #2 clk = ~clk;

  vehicle_power_state_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // One control tick of the sequencer. Order matters: countdowns first, then the
  // failed retry, then the fault override, then the LV/HV/RTD stepping.
  function automatic vpss_out_t predict_tick(vpss_in_t req);
    logic      hv_on;
    logic      send;
    vpss_out_t res;
    hv_on = req.bms_valid & req.contactor_closed;
    if (veh.hv_ticks_left != '0) veh.hv_ticks_left = veh.hv_ticks_left - 1'b1;
    if (veh.buzzer_ticks_left != '0) veh.buzzer_ticks_left = veh.buzzer_ticks_left - 1'b1;
    if (veh.mode == MODE_FAILED) veh.mode = MODE_LV;
    if (req.inverters_invalid || !req.eeprom_ready) veh.mode = MODE_FAILED;
    if (veh.mode == MODE_LV) begin
      // entering HV does not reload the inactivity countdown
      if (hv_on) veh.mode = MODE_HV;
    end else if (veh.mode == MODE_HV || veh.mode == MODE_RTD) begin
      if (veh.mode == MODE_HV && req.braking && !req.accelerating && !req.button_line) begin
        veh.mode = MODE_RTD;
        veh.buzzer_ticks_left = regs.buzzer_ticks;
      end
      // an RTD entry on this tick can still be undone here; buzzer keeps running
      if (hv_on) veh.hv_ticks_left = regs.hv_timeout_ticks;
      else if (veh.hv_ticks_left == '0) veh.mode = MODE_LV;
    end
    // 8-bit wrap; a prescale of zero, or one lowered under the count, sends at once
    veh.message_count = veh.message_count + 1'b1;
    send = (veh.message_count >= regs.status_prescale);
    if (send) veh.message_count = '0;
    res.vehicle_state = veh.mode;
    res.cooling_on    = (veh.mode == MODE_HV) || (veh.mode == MODE_RTD);
    res.buzzer_on     = (veh.buzzer_ticks_left != '0);
    res.fault_led     = !req.torque_plausible || (veh.mode == MODE_FAILED);
    res.brake_light   = req.braking;
    res.send_status   = send;
    return res;
  endfunction

  // Mostly healthy requests around a slowly toggling HV level; faults are rare.
  function automatic vpss_in_t shaped_request(bit hv_up);
    vpss_in_t r;
    r.inverters_invalid = ($urandom_range(0, 31) == 0);
    r.eeprom_ready      = ($urandom_range(0, 31) != 0);
    if (hv_up) begin
      r.bms_valid        = ($urandom_range(0, 15) != 0);
      r.contactor_closed = ($urandom_range(0, 15) != 0);
    end else begin
      r.bms_valid        = 1'($urandom_range(0, 1));
      r.contactor_closed = ($urandom_range(0, 3) == 0);
    end
    r.braking          = 1'($urandom_range(0, 1));
    r.accelerating     = ($urandom_range(0, 3) == 0);
    r.button_line      = 1'($urandom_range(0, 1));
    r.torque_plausible = ($urandom_range(0, 7) != 0);
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int exp_val);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch on result %0d: %s got %0d want %0d",
               $realtime, results_seen, what, got, exp_val);
  endtask

  // Offer one request after a random gap; valid stays up until it is taken.
  // The prediction is made at the accepting edge.
  task automatic send_request(vpss_in_t req);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!(in_valid && in_ready));
    due_outputs.push_back(predict_tick(req));
  endtask

  // Drop valid and wait until every predicted status has come back, then allow
  // some slack.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_BUZZER_TICKS:     regs.buzzer_ticks     = val[BuzzerW-1:0];
      REG_HV_TIMEOUT_TICKS: regs.hv_timeout_ticks = val[HvW-1:0];
      REG_STATUS_PRESCALE:  regs.status_prescale  = val[MsgW-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(int buzz, int hv_to, int presc);
    settle();
    write_reg(REG_BUZZER_TICKS, CfgW'(buzz));
    write_reg(REG_HV_TIMEOUT_TICKS, CfgW'(hv_to));
    write_reg(REG_STATUS_PRESCALE, CfgW'(presc));
  endtask

  // Walk the state machine through every mode and its fault, retry, HV and RTD entries at reset settings.
  task automatic test_directed_sequence();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_request(REQ_LV_IDLE);
    send_request(REQ_INV_BAD);     // -> failed
    send_request(REQ_LV_IDLE);     // failed retries low voltage
    send_request(REQ_EEPROM_OFF);  // -> failed
    send_request(REQ_HV_UP);       // retry, then HV present -> HV, countdown still zero
    send_request(REQ_RTD_NO_HV);   // RTD entry undone by expired HV; buzzer still loads
    send_request(REQ_HV_UP);
    send_request(REQ_IMPLAUS);     // fault lamp from torque alone
    send_request(REQ_RTD_ACCEL);   // accelerator blocks RTD
    send_request(REQ_RTD_GO);      // -> RTD
    send_request(REQ_HV_UP);
    send_request(REQ_BMS_ONLY);    // HV absent, countdown running
    send_request(REQ_CONT_ONLY);
    send_request(REQ_ALL_ONES);    // failed overrides everything
    send_request(REQ_ALL_ZEROS);   // retry, then failed again
  endtask

  // Zero and full-scale register values, then a prescale lowered under the count.
  task automatic test_register_extremes();
    apply_settings(0, 0, 0);
    send_request(REQ_LV_IDLE);     // zero prescale sends every tick
    send_request(REQ_HV_UP);
    send_request(REQ_RTD_GO);      // zero buzzer time: buzzer off from this entry
    send_request(REQ_BMS_ONLY);    // zero timeout drops on first absence
    apply_settings(1023, 255, 255);
    send_request(REQ_HV_UP);
    send_request(REQ_RTD_GO);
    send_request(REQ_CONT_ONLY);
    settle();
    write_reg(REG_STATUS_PRESCALE, CfgW'(2));  // count already above new prescale
    send_request(REQ_LV_IDLE);
    send_request(REQ_LV_IDLE);
  endtask

  // Receiver holds off while the sender keeps offering back to back.
  task automatic test_backpressure();
    settle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_cycles = HOLD_OFF_CYCLES;
    for (int i = 0; i < 20; i++) send_request(shaped_request(1'b1));
  endtask

  task automatic test_random_phases();
    bit           hv_up;
    logic [7:0]   raw;
    hv_up = 1'b0;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(BUZZER_TICKS_RST, HV_TIMEOUT_TICKS_RST, STATUS_PRESCALE_RST);
        1: apply_settings(1, 1, 1);
        2: apply_settings(1023, 255, 255);
        3: apply_settings(0, 0, 0);
        default: apply_settings($urandom_range(0, 1) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, 1023),
                                $urandom_range(0, 1) ? $urandom_range(0, 12)
                                                     : $urandom_range(0, 255),
                                $urandom_range(0, 1) ? $urandom_range(0, 12)
                                                     : $urandom_range(0, 255));
      endcase
      // first phase runs flat out; the rest mix gaps and stalls at random
      tx_idle = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_idle = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      for (int i = 0; i < 78; i++) begin
        if ($urandom_range(0, 9) == 0) hv_up = !hv_up;
        if ($urandom_range(0, 7) == 0) begin
          raw = 8'($urandom_range(0, 255));  // unshaped noise
          send_request(raw);
        end else begin
          send_request(shaped_request(hv_up));
        end
      end
    end
  endtask

  // Result side: per-result stall, or the long hold-off when one is requested.
  initial begin : result_drain
    int stall;
    forever begin
      stall = (hold_cycles != 0) ? hold_cycles : (rx_idle ? $urandom_range(0, 14) : 0);
      hold_cycles = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Compare every accepted status word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_outputs.size() == 0) begin
        flag_mismatch("result with nothing pending", out_data, 0);
      end else begin
        want = due_outputs.pop_front();
        if (out_data.vehicle_state !== want.vehicle_state)
          flag_mismatch("vehicle_state", out_data.vehicle_state, want.vehicle_state);
        if (out_data.cooling_on !== want.cooling_on)
          flag_mismatch("cooling_on", out_data.cooling_on, want.cooling_on);
        if (out_data.buzzer_on !== want.buzzer_on)
          flag_mismatch("buzzer_on", out_data.buzzer_on, want.buzzer_on);
        if (out_data.fault_led !== want.fault_led)
          flag_mismatch("fault_led", out_data.fault_led, want.fault_led);
        if (out_data.brake_light !== want.brake_light)
          flag_mismatch("brake_light", out_data.brake_light, want.brake_light);
        if (out_data.send_status !== want.send_status)
          flag_mismatch("send_status", out_data.send_status, want.send_status);
      end
      results_seen++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // predictor comes up exactly as the block does out of reset
    veh.mode              = MODE_LV;
    veh.hv_ticks_left     = '0;
    veh.buzzer_ticks_left = '0;
    veh.message_count     = '0;
    regs.buzzer_ticks     = BUZZER_TICKS_RST;
    regs.hv_timeout_ticks = HV_TIMEOUT_TICKS_RST;
    regs.status_prescale  = STATUS_PRESCALE_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_sequence();
    test_register_extremes();
    test_backpressure();
    test_random_phases();

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
